// File: design/tsf_pkg.sv
// Shared constants and payload types for the triangle strip flattener.
package tsf_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int INDEX_WIDTH = 32;
  localparam logic [FIELD_WIDTH-1:0] RESTART_RESET = 32'hffff_ffff;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] vertex_index;
    logic                   last;
  } tsf_in_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] corner_a;
    logic [FIELD_WIDTH-1:0] corner_b;
    logic [FIELD_WIDTH-1:0] corner_c;
  } tsf_out_t;

  typedef struct packed {
    logic     valid;
    tsf_out_t corners;
  } tsf_result_t;

endpackage

// File: design/triangle_strip_flattener.sv
// Triangle strip flattener: top level joining strip assembly and result register.
// Triangles are built combinationally, then registered in the output or skid stage.
// Throughput: one index per cycle unless in_stall; strip state updates on each take.
// Main and skid registers let input run while output stalls, until the skid is full.
// Reset: synchronous, clears strip state, output valids; restart value to all ones.
module triangle_strip_flattener (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tsf_pkg::tsf_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tsf_pkg::tsf_out_t               out_data,
  input  logic                            cfg_wr_en,
  input  logic [tsf_pkg::FIELD_WIDTH-1:0] cfg_wr_data
);
  import tsf_pkg::*;

  tsf_result_t result;
  logic        full;
  logic        take;

  assign in_stall = full;
  assign take     = in_valid & ~full;

  tsf_assemble u_assemble (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (result)
  );

  tsf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: design/tsf_assemble.sv
// Strip state, restart register and triangle assembly for one index per cycle on take.
module tsf_assemble (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  tsf_pkg::tsf_in_t                in_data,
  input  logic                            cfg_wr_en,
  input  logic [tsf_pkg::FIELD_WIDTH-1:0] cfg_wr_data,
  output tsf_pkg::tsf_result_t            result
);
  import tsf_pkg::*;

  logic [FIELD_WIDTH-1:0] restart_value;
  logic [INDEX_WIDTH-1:0] older_index, older_index_next;
  logic [INDEX_WIDTH-1:0] newer_index, newer_index_next;
  logic [1:0]             strip_fill, strip_fill_next;
  logic                   odd_face, odd_face_next;

  logic [INDEX_WIDTH-1:0] v;
  logic [INDEX_WIDTH-1:0] cut;

  assign v   = in_data.vertex_index[INDEX_WIDTH-1:0];
  assign cut = restart_value[INDEX_WIDTH-1:0];

  always_comb begin
    older_index_next = older_index;
    newer_index_next = newer_index;
    strip_fill_next  = strip_fill;
    odd_face_next    = odd_face;
    result.valid            = 1'b0;
    result.corners.corner_a = FIELD_WIDTH'(older_index);
    result.corners.corner_b = odd_face ? FIELD_WIDTH'(v) : FIELD_WIDTH'(newer_index);
    result.corners.corner_c = odd_face ? FIELD_WIDTH'(newer_index) : FIELD_WIDTH'(v);
    if (v == cut) begin
      strip_fill_next = 2'd0;
      odd_face_next   = 1'b0;
    end else if (strip_fill < 2'd2) begin
      older_index_next = newer_index;
      newer_index_next = v;
      strip_fill_next  = strip_fill + 2'd1;
    end else begin
      result.valid     = take;
      odd_face_next    = ~odd_face;
      older_index_next = newer_index;
      newer_index_next = v;
    end
    if (in_data.last) begin
      older_index_next = '0;
      newer_index_next = '0;
      strip_fill_next  = 2'd0;
      odd_face_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      restart_value <= RESTART_RESET;
      older_index   <= '0;
      newer_index   <= '0;
      strip_fill    <= 2'd0;
      odd_face      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        restart_value <= cfg_wr_data;
      end
      if (take) begin
        older_index <= older_index_next;
        newer_index <= newer_index_next;
        strip_fill  <= strip_fill_next;
        odd_face    <= odd_face_next;
      end
    end
  end

endmodule

// File: design/tsf_out_reg.sv
// Result register with a skid stage between assembly and the output channel.
module tsf_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  tsf_pkg::tsf_result_t push,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tsf_pkg::tsf_out_t    out_data
);
  import tsf_pkg::*;

  logic     main_valid;
  logic     skid_valid;
  tsf_out_t main_data;
  tsf_out_t skid_data;
  logic     pop;

  assign pop       = main_valid & ~out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push.valid) begin
      if (!main_valid || pop) begin
        main_data <= push.corners;
      end else begin
        skid_data <= push.corners;
      end
    end
  end

endmodule

// File: bench/strip_checker.sv
// Checker for the triangle strip flattener: predicts triangles and compares transfers.
`timescale 1ns / 1ps

module strip_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  tsf_pkg::tsf_in_t                in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  tsf_pkg::tsf_out_t               out_data,
  input  logic                            cfg_wr_en,
  input  logic [tsf_pkg::FIELD_WIDTH-1:0] cfg_wr_data,
  output int                              errors,
  output int                              pending
);
  import tsf_pkg::*;

  localparam logic [FIELD_WIDTH-1:0] IDX_MASK =
    {FIELD_WIDTH{1'b1}} >> (FIELD_WIDTH - INDEX_WIDTH);

  logic [FIELD_WIDTH-1:0] cut_value;
  logic [FIELD_WIDTH-1:0] older;
  logic [FIELD_WIDTH-1:0] newer;
  logic [FIELD_WIDTH-1:0] vtx;
  logic [1:0]             fill;
  logic                   odd_next;
  tsf_out_t               triangles_due[$];
  tsf_out_t               due;
  tsf_out_t               made;
  int                     bad;

  always @(posedge clk) begin
    bad = 0;
    if (rst) begin
      cut_value = RESTART_RESET;
      older     = '0;
      newer     = '0;
      fill      = '0;
      odd_next  = 1'b0;
      triangles_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (triangles_due.size() == 0) begin
          $error("triangle %h %h %h with none predicted",
                 out_data.corner_a, out_data.corner_b, out_data.corner_c);
          bad++;
        end else begin
          due = triangles_due.pop_front();
          if (out_data.corner_a !== due.corner_a) begin
            $error("corner_a expected %h got %h", due.corner_a, out_data.corner_a);
            bad++;
          end
          if (out_data.corner_b !== due.corner_b) begin
            $error("corner_b expected %h got %h", due.corner_b, out_data.corner_b);
            bad++;
          end
          if (out_data.corner_c !== due.corner_c) begin
            $error("corner_c expected %h got %h", due.corner_c, out_data.corner_c);
            bad++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        vtx = in_data.vertex_index & IDX_MASK;
        if (vtx == (cut_value & IDX_MASK)) begin
          fill     = '0;
          odd_next = 1'b0;
        end else if (fill < 2'd2) begin
          older = newer;
          newer = vtx;
          fill  = fill + 2'd1;
        end else begin
          made.corner_a = older;
          made.corner_b = odd_next ? vtx : newer;
          made.corner_c = odd_next ? newer : vtx;
          triangles_due.insert(triangles_due.size(), made);
          odd_next = !odd_next;
          older    = newer;
          newer    = vtx;
        end
        if (in_data.last) begin
          older    = '0;
          newer    = '0;
          fill     = '0;
          odd_next = 1'b0;
        end
      end
      if (cfg_wr_en) cut_value = cfg_wr_data;
    end
    errors  <= errors + bad;
    pending <= triangles_due.size();
  end

endmodule

// File: bench/tb.sv
// Testbench top for the triangle strip flattener: stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import tsf_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_ITEMS = 175;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  tsf_in_t                in_data;
  logic                   out_valid;
  logic                   out_stall;
  tsf_out_t               out_data;
  logic                   cfg_wr_en;
  logic [FIELD_WIDTH-1:0] cfg_wr_data;
  logic                   steady = 1'b0;
  logic [FIELD_WIDTH-1:0] cut_now = RESTART_RESET;
  int                     fail_count;
  int                     pending_count;
  int                     idle_cycles = 0;

  triangle_strip_flattener dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  strip_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (fail_count),
    .pending     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input logic [FIELD_WIDTH-1:0] idx, input logic lst);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{vertex_index: idx, last: lst};
    @(posedge clk iff !in_stall);
  endtask

  // drain every predicted triangle, then write the restart value
  task automatic set_restart(input logic [FIELD_WIDTH-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    cut_now      = val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [FIELD_WIDTH-1:0] pick_index(input logic [FIELD_WIDTH-1:0] cut);
    int r;
    r = $urandom_range(99);
    if (r < 8) return cut;
    if (r < 11) return cut + 1;
    if (r < 14) return cut - 1;
    if (r < 18) return r[0] ? '0 : '1;
    return $urandom;
  endfunction

  // receiver: random stalls, one long hold-off once traffic is flowing
  initial begin
    int  seen;
    bit  held;
    seen = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) seen++;
      if (!held && seen >= 380) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      out_stall <= !steady && ($urandom_range(99) < 7);
    end
  end

  initial begin
    logic [FIELD_WIDTH-1:0] val;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(32'h0000_0000, 1'b0);
    send(32'hffff_fffe, 1'b0);
    send(32'h7fff_ffff, 1'b0);
    send(32'h8000_0000, 1'b0);
    send(32'h0000_0001, 1'b0);
    send(32'hffff_ffff, 1'b0);
    send(32'h0000_0005, 1'b0);
    send(32'hffff_ffff, 1'b0);
    send(32'hffff_ffff, 1'b0);
    send(32'h0000_000a, 1'b0);
    send(32'h0000_000b, 1'b0);
    send(32'h0000_000c, 1'b1);
    send(32'h0000_0014, 1'b0);
    send(32'h0000_0015, 1'b1);
    send(32'h0000_001e, 1'b0);
    send(32'hffff_ffff, 1'b1);

    set_restart('0);
    send(32'h0000_0000, 1'b0);
    send(32'h0000_0003, 1'b0);
    send(32'h0000_0000, 1'b0);
    send(32'h0000_0005, 1'b0);
    send(32'h0000_0006, 1'b0);
    send(32'hffff_ffff, 1'b0);
    send(32'h0000_0007, 1'b1);

    for (int p = 0; p < 6; p++) begin
      if (p == 0) val = '0;
      else if (p == 5) val = '1;
      else val = $urandom;
      set_restart(val);
      steady = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send(pick_index(cut_now), $urandom_range(99) < 3);
      end
      steady = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: triangle_strip_flattener.f
design/tsf_pkg.sv
design/tsf_assemble.sv
design/tsf_out_reg.sv
design/triangle_strip_flattener.sv
bench/strip_checker.sv
bench/tb.sv
